// File: rtl/bled_pkg.sv
// Shared types and helpers for the bytes literal escape decoder.
// Holds the channel payload structs, result kinds and the front-to-back record.
// No dependencies.
package bled_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_source;
  } src_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_out;
    logic [15:0] byte_count;
    logic        run_end;
  } res_t;

  // An accepted character yields up to two results; they travel together.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } rec_t;

  localparam int QUEUE_DEPTH = 2;

  function automatic res_t mk_byte(input logic [7:0] b);
    res_t r;
    r.kind       = KIND_BYTE;
    r.byte_out   = b;
    r.byte_count = 16'd0;
    r.run_end    = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_err();
    res_t r;
    r.kind       = KIND_ERR;
    r.byte_out   = 8'd0;
    r.byte_count = 16'd0;
    r.run_end    = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_done(input logic [15:0] n);
    res_t r;
    r.kind       = KIND_DONE;
    r.byte_out   = 8'd0;
    r.byte_count = n;
    r.run_end    = 1'b0;
    return r;
  endfunction

endpackage

// File: rtl/bytes_literal_escape_decoder_core.sv
// Bytes literal escape decoder, top level.
// Instantiates bled_front, bled_queue and bled_back; uses bled_pkg.
//
// The src channel takes one source character per word (char_in plus an
// end_of_source mark) of the literal text: b or B prefix, quote, body, quote,
// repeated for concatenated tokens. The res channel gives decoded bytes, a
// done word carrying the byte count after the final close, or an error word.
// run_end marks the last result word caused by one source character.
//
// A character is decoded in the cycle it is accepted and its results are
// queued, then pass through the output register to res. One character is
// taken per cycle while the queue has room. A character that ends a short
// octal escape and is itself a byte, or that closes the final token after
// it, gives two result words, which the output stage presents in turn. With
// characters arriving every cycle and res_ready high, each such character
// fills the queue and drops src_ready; a gap in the input right after it
// hides that stall. When the receiver stalls, res holds its word, the queue
// fills and src_ready falls once both queue entries are taken. Reset returns
// the token state to expecting a prefix and empties the queue and output register.
module bytes_literal_escape_decoder_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           src_valid,
  output logic           src_ready,
  input  bled_pkg::src_t src_data,
  output logic           res_valid,
  input  logic           res_ready,
  output bled_pkg::res_t res_data
);

  logic           accept, push, pop, full, nonempty;
  bled_pkg::rec_t push_rec, head;

  assign src_ready = !full;
  assign accept    = src_valid && src_ready;

  bled_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .src    (src_data),
    .push   (push),
    .rec    (push_rec)
  );

  bled_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .full     (full),
    .nonempty (nonempty),
    .head     (head)
  );

  bled_back u_back (
    .clk       (clk),
    .rst       (rst),
    .nonempty  (nonempty),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule

// File: rtl/bled_front.sv
// Front part of the decoder: accepts characters, tracks the token and escape
// state, and builds one record of results per character. Uses bled_pkg.
module bled_front #(
  parameter int COUNT_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  bled_pkg::src_t  src,
  output logic            push,
  output bled_pkg::rec_t  rec
);

  typedef enum logic [7:0] {
    PH_PREFIX = 8'b0000_0001,
    PH_QUOTE  = 8'b0000_0010,
    PH_BODY   = 8'b0000_0100,
    PH_ESC    = 8'b0000_1000,
    PH_HEX    = 8'b0001_0000,
    PH_OCT    = 8'b0010_0000,
    PH_CLOSED = 8'b0100_0000,
    PH_ERROR  = 8'b1000_0000
  } phase_t;

  localparam logic [7:0] ESC_BEL = 8'd7;
  localparam logic [7:0] ESC_BS  = 8'd8;
  localparam logic [7:0] ESC_TAB = 8'd9;
  localparam logic [7:0] ESC_LF  = 8'd10;
  localparam logic [7:0] ESC_VT  = 8'd11;
  localparam logic [7:0] ESC_FF  = 8'd12;
  localparam logic [7:0] ESC_CR  = 8'd13;
  localparam logic [7:0] ESC_ESC = 8'd27;
  localparam logic [7:0] CH_BSL  = 8'h5C;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam int WIDE = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  function automatic logic hex_ok(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c <= "9") v = c - "0";
    else if (c >= "a") v = c - "a" + 8'd10;
    else v = c - "A" + 8'd10;
    return v[3:0];
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return c >= "0" && c <= "7";
  endfunction

  phase_t                phase, phase_next;
  logic [7:0]            quote_char, quote_char_next;
  logic [8:0]            escape_accum, escape_accum_next;
  logic [1:0]            digit_count, digit_count_next;
  logic [COUNT_BITS-1:0] decoded_count, decoded_count_next;

  logic [1:0]            nres, emits;
  bled_pkg::res_t        r0, r1;
  logic [7:0]            c;
  logic [8:0]            oct_acc;
  logic [COUNT_BITS:0]   cnt_sum;
  logic [COUNT_BITS-1:0] cnt_sat;
  logic [WIDE-1:0]       cnt_wide;
  logic [15:0]           done_count;
  logic                  was_error;

  always_comb begin
    c                  = src.char_in;
    was_error          = (phase == PH_ERROR);
    phase_next         = phase;
    quote_char_next    = quote_char;
    escape_accum_next  = escape_accum;
    digit_count_next   = digit_count;
    nres               = 2'd0;
    emits              = 2'd0;
    r0                 = bled_pkg::mk_err();
    r1                 = bled_pkg::mk_err();
    oct_acc            = {escape_accum[5:0], c[2:0]};

    case (phase)
      PH_PREFIX, PH_CLOSED: begin
        if (c == "b" || c == "B") begin
          phase_next = PH_QUOTE;
        end else begin
          nres = 2'd1; phase_next = PH_ERROR;
        end
      end
      PH_QUOTE: begin
        if (c == "'" || c == "\"") begin
          quote_char_next = c;
          phase_next      = PH_BODY;
        end else begin
          nres = 2'd1; phase_next = PH_ERROR;
        end
      end
      PH_BODY: begin
        if (c == quote_char) phase_next = PH_CLOSED;
        else if (c == CH_BSL) phase_next = PH_ESC;
        else begin
          r0 = bled_pkg::mk_byte(c); nres = 2'd1; emits = 2'd1;
        end
      end
      PH_ESC: begin
        phase_next = PH_BODY;
        nres       = 2'd1;
        emits      = 2'd1;
        if (c == quote_char) begin
          r0 = bled_pkg::mk_byte(c);
        end else if (c == "x" || c == "X") begin
          escape_accum_next = 9'd0;
          digit_count_next  = 2'd0;
          phase_next        = PH_HEX;
          nres = 2'd0; emits = 2'd0;
        end else if (is_oct(c)) begin
          escape_accum_next = {6'd0, c[2:0]};
          digit_count_next  = 2'd1;
          phase_next        = PH_OCT;
          nres = 2'd0; emits = 2'd0;
        end else begin
          case (c)
            "a":     r0 = bled_pkg::mk_byte(ESC_BEL);
            "b":     r0 = bled_pkg::mk_byte(ESC_BS);
            "e":     r0 = bled_pkg::mk_byte(ESC_ESC);
            "f":     r0 = bled_pkg::mk_byte(ESC_FF);
            "n":     r0 = bled_pkg::mk_byte(ESC_LF);
            "r":     r0 = bled_pkg::mk_byte(ESC_CR);
            "t":     r0 = bled_pkg::mk_byte(ESC_TAB);
            "v":     r0 = bled_pkg::mk_byte(ESC_VT);
            CH_BSL:  r0 = bled_pkg::mk_byte(CH_BSL);
            default: begin
              emits = 2'd0; phase_next = PH_ERROR;
            end
          endcase
        end
      end
      PH_HEX: begin
        if (!hex_ok(c)) begin
          nres = 2'd1; phase_next = PH_ERROR;
        end else if (digit_count == 2'd0) begin
          escape_accum_next = {5'd0, hex_val(c)};
          digit_count_next  = 2'd1;
        end else begin
          r0 = bled_pkg::mk_byte({escape_accum[3:0], hex_val(c)});
          nres = 2'd1; emits = 2'd1;
          escape_accum_next = 9'd0;
          digit_count_next  = 2'd0;
          phase_next        = PH_BODY;
        end
      end
      PH_OCT: begin
        if (is_oct(c)) begin
          escape_accum_next = oct_acc;
          digit_count_next  = digit_count + 2'd1;
          if (digit_count == 2'd2) begin
            escape_accum_next = 9'd0;
            digit_count_next  = 2'd0;
            nres              = 2'd1;
            if (oct_acc[8]) begin
              phase_next = PH_ERROR;
            end else begin
              r0 = bled_pkg::mk_byte(oct_acc[7:0]); emits = 2'd1;
              phase_next = PH_BODY;
            end
          end
        end else begin
          // A short octal escape ends here; the character is then a body character.
          r0 = bled_pkg::mk_byte(escape_accum[7:0]);
          nres = 2'd1; emits = 2'd1;
          escape_accum_next = 9'd0;
          digit_count_next  = 2'd0;
          if (c == quote_char) phase_next = PH_CLOSED;
          else if (c == CH_BSL) phase_next = PH_ESC;
          else begin
            phase_next = PH_BODY;
            r1 = bled_pkg::mk_byte(c); nres = 2'd2; emits = 2'd2;
          end
        end
      end
      default: phase_next = PH_ERROR;
    endcase

    cnt_sum = {1'b0, decoded_count} + {{(COUNT_BITS-1){1'b0}}, emits};
    cnt_sat = (cnt_sum > {1'b0, CNT_MAX}) ? CNT_MAX : cnt_sum[COUNT_BITS-1:0];
    decoded_count_next = cnt_sat;
    cnt_wide   = WIDE'(cnt_sat);
    done_count = (cnt_wide > WIDE'(16'hFFFF)) ? 16'hFFFF : cnt_wide[15:0];

    if (src.end_of_source) begin
      if (phase_next == PH_CLOSED) begin
        if (nres == 2'd0) r0 = bled_pkg::mk_done(done_count);
        else r1 = bled_pkg::mk_done(done_count);
        nres = nres + 2'd1;
      end else if (was_error) begin
        nres = 2'd0;
      end else if (phase_next != PH_ERROR) begin
        // Unterminated token: one error replaces whatever this step produced.
        r0   = bled_pkg::mk_err();
        nres = 2'd1;
      end
      phase_next         = PH_PREFIX;
      quote_char_next    = 8'd0;
      escape_accum_next  = 9'd0;
      digit_count_next   = 2'd0;
      decoded_count_next = '0;
    end

    r0.run_end = (nres == 2'd1);
    r1.run_end = 1'b1;
    rec.two    = (nres == 2'd2);
    rec.r0     = r0;
    rec.r1     = r1;
    push       = accept && (nres != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_PREFIX;
      quote_char    <= 8'd0;
      escape_accum  <= 9'd0;
      digit_count   <= 2'd0;
      decoded_count <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      quote_char    <= quote_char_next;
      escape_accum  <= escape_accum_next;
      digit_count   <= digit_count_next;
      decoded_count <= decoded_count_next;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (rst)
    accept && src.end_of_source |=> phase == PH_PREFIX && decoded_count == '0)
    else $error("state not cleared after end of source");

  a_discard: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_ERROR |-> !push)
    else $error("result produced while discarding after an error");

  a_two: assert property (@(posedge clk) disable iff (rst)
    push && rec.two |-> phase == PH_OCT || src.end_of_source)
    else $error("two results outside an octal end or final close");

endmodule

// File: rtl/bled_queue.sv
// Short record queue between the front and back parts of the decoder.
// Uses bled_pkg for the record type and depth.
module bled_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bled_pkg::rec_t push_rec,
  input  logic           pop,
  output logic           full,
  output logic           nonempty,
  output bled_pkg::rec_t head
);

  localparam int PW = $clog2(bled_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(bled_pkg::QUEUE_DEPTH + 1);

  bled_pkg::rec_t entries [bled_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wptr, rptr;
  logic [CW-1:0]  count;

  assign full     = (count == CW'(bled_pkg::QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = entries[rptr];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(bled_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= ptr_inc(wptr);
      if (pop) rptr <= ptr_inc(rptr);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && push |-> pop)
    else $error("record pushed into a full queue");

endmodule

// File: rtl/bled_back.sv
// Back part of the decoder: unpacks queued records into single results and
// holds each in the output register until taken. Uses bled_pkg.
module bled_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           nonempty,
  input  bled_pkg::rec_t head,
  output logic           pop,
  output logic           res_valid,
  input  logic           res_ready,
  output bled_pkg::res_t res_data
);

  logic take;
  logic second;

  assign take = !res_valid || res_ready;
  assign pop  = take && nonempty && (second || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      second    <= 1'b0;
    end else if (take) begin
      res_valid <= nonempty;
      if (nonempty) second <= !second && head.two;
    end
  end

  always_ff @(posedge clk) begin
    if (take && nonempty) res_data <= second ? head.r1 : head.r0;
  end

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for bytes_literal_escape_decoder_core.
// Streams literal source text into the block, predicts decoded words internally and
// checks every result word in order. Depends on bled_pkg and the core RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_CHARS = 1450;
  localparam int TAIL_CYCLES  = 20;

  typedef enum logic [3:0] {
    ST_PREFIX, ST_QUOTE, ST_BODY, ST_ESC, ST_HEX, ST_OCT, ST_CLOSED, ST_ERROR
  } scan_state_t;

  logic clk = 1'b0;
  logic rst;
  logic src_valid;
  logic src_ready;
  bled_pkg::src_t src_data;
  logic res_valid;
  logic res_ready;
  bled_pkg::res_t res_data;

  bytes_literal_escape_decoder_core #(.COUNT_BITS(16)) DUT (
    .clk      (clk),
    .rst      (rst),
    .src_valid(src_valid),
    .src_ready(src_ready),
    .src_data (src_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

  always #1 clk = ~clk;

  // Decoder state as the testbench sees it.
  scan_state_t scan_st = ST_PREFIX;
  logic [7:0]  quote_ch = 8'd0;
  logic [8:0]  accum = 9'd0;
  int          digits = 0;
  logic [15:0] decoded_total = 16'd0;

  bled_pkg::res_t step_words[$];
  bled_pkg::res_t pending_words[$];
  int   chars_sent = 0;
  int   mismatch_count = 0;
  bit   steady_flow = 1'b0;

  function automatic bled_pkg::res_t make_word(bled_pkg::kind_t k, logic [7:0] b);
    bled_pkg::res_t w;
    w.kind       = k;
    w.byte_out   = b;
    w.byte_count = 16'd0;
    w.run_end    = 1'b0;
    return w;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    step_words.push_back(make_word(bled_pkg::KIND_BYTE, b));
    if (decoded_total < 16'hFFFF) decoded_total++;
  endfunction

  function automatic void fail_literal();
    step_words.push_back(make_word(bled_pkg::KIND_ERR, 8'd0));
    scan_st = ST_ERROR;
  endfunction

  function automatic int hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void take_body(logic [7:0] c);
    if (c == quote_ch) scan_st = ST_CLOSED;
    else if (c == "\\") scan_st = ST_ESC;
    else put_byte(c);
  endfunction

  function automatic void take_escape(logic [7:0] c);
    logic [7:0] v;
    if (c == quote_ch) begin
      put_byte(c);
      scan_st = ST_BODY;
      return;
    end
    if (c == "x" || c == "X") begin
      accum   = 9'd0;
      digits  = 0;
      scan_st = ST_HEX;
      return;
    end
    if (c >= "0" && c <= "7") begin
      accum   = {6'd0, c[2:0]};
      digits  = 1;
      scan_st = ST_OCT;
      return;
    end
    case (c)
      "a": v = 8'd7;
      "b": v = 8'd8;
      "e": v = 8'd27;
      "f": v = 8'd12;
      "n": v = 8'd10;
      "r": v = 8'd13;
      "t": v = 8'd9;
      "v": v = 8'd11;
      "\\": v = "\\";
      default: begin
        fail_literal();
        return;
      end
    endcase
    put_byte(v);
    scan_st = ST_BODY;
  endfunction

  // Works out the result words of one accepted character and queues them.
  function automatic void decode_char(logic [7:0] c, logic last);
    logic was_err;
    int   hv;
    was_err = (scan_st == ST_ERROR);
    step_words.delete();
    case (scan_st)
      ST_PREFIX, ST_CLOSED: begin
        if (c == "b" || c == "B") scan_st = ST_QUOTE;
        else fail_literal();
      end
      ST_QUOTE: begin
        if (c == "'" || c == "\"") begin
          quote_ch = c;
          scan_st  = ST_BODY;
        end else begin
          fail_literal();
        end
      end
      ST_BODY: take_body(c);
      ST_ESC: take_escape(c);
      ST_HEX: begin
        hv = hex_value(c);
        if (hv < 0) begin
          fail_literal();
        end else if (digits == 0) begin
          accum  = 9'(hv);
          digits = 1;
        end else begin
          put_byte({accum[3:0], hv[3:0]});
          accum   = 9'd0;
          digits  = 0;
          scan_st = ST_BODY;
        end
      end
      ST_OCT: begin
        if (c >= "0" && c <= "7") begin
          accum  = (accum << 3) + c[2:0];
          digits = digits + 1;
          if (digits >= 3) begin
            if (accum >= 9'd256) fail_literal();
            else begin
              put_byte(accum[7:0]);
              scan_st = ST_BODY;
            end
            accum  = 9'd0;
            digits = 0;
          end
        end else begin
          // A short octal escape ends here; the character itself is body text.
          put_byte(accum[7:0]);
          accum   = 9'd0;
          digits  = 0;
          scan_st = ST_BODY;
          take_body(c);
        end
      end
      default: scan_st = ST_ERROR;
    endcase

    if (last) begin
      if (scan_st == ST_CLOSED) begin
        step_words.push_back(make_word(bled_pkg::KIND_DONE, 8'd0));
        step_words[step_words.size()-1].byte_count = decoded_total;
      end else if (!was_err && scan_st != ST_ERROR) begin
        // Source ended inside a token: only an error word comes out.
        step_words.delete();
        step_words.push_back(make_word(bled_pkg::KIND_ERR, 8'd0));
      end else if (was_err) begin
        step_words.delete();
      end
      scan_st       = ST_PREFIX;
      quote_ch      = 8'd0;
      accum         = 9'd0;
      digits        = 0;
      decoded_total = 16'd0;
    end

    foreach (step_words[i]) begin
      if (i == step_words.size() - 1) step_words[i].run_end = 1'b1;
      pending_words.push_back(step_words[i]);
    end
  endfunction

  task automatic log_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH: %s", msg);
  endtask

  task automatic send_char(logic [7:0] c, logic last);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_data  <= '{char_in: c, end_of_source: last};
    do @(posedge clk); while (!src_ready);
    decode_char(c, last);
    chars_sent++;
  endtask

  task automatic send_text(logic [7:0] text[$]);
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  task automatic send_string(string s);
    logic [7:0] text[$];
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_text(text);
  endtask

  task automatic test_octal_end();
    // The second digit is not octal, so one character gives two words.
    send_string("B\"\\09\"");
  endtask

  task automatic test_octal_overflow();
    send_string("b'\\400'");
  endtask

  task automatic test_bad_prefix();
    send_string("q");
  endtask

  task automatic test_bad_quote();
    send_string("bx");
  endtask

  task automatic test_unterminated();
    send_string("b'a");
  endtask

  task automatic test_trailing_text();
    send_string("b''z");
  endtask

  task automatic test_raw_extremes();
    logic [7:0] text[$];
    text = '{"b", "'", 8'h00, 8'hFF, "'"};
    send_text(text);
  endtask

  task automatic test_random_literals();
    logic [7:0] text[$];
    logic [7:0] q;
    logic [7:0] ch;
    string      named_set;
    string      hex_set;
    int         start;
    int         ntok;
    int         nelem;
    int         nd;
    int         flavor;
    int         pos;
    named_set = "abefnrtv\\";
    hex_set   = "0123456789abcdefABCDEF";
    start     = chars_sent;
    while (chars_sent - start < RANDOM_CHARS) begin
      text.delete();
      steady_flow = ($urandom_range(0, 7) == 0);
      flavor      = $urandom_range(0, 19);
      if (flavor < 2) begin
        nelem = $urandom_range(1, 6);
        repeat (nelem) text.push_back(8'($urandom_range(0, 255)));
      end else begin
        ntok = $urandom_range(1, 3);
        repeat (ntok) begin
          text.push_back($urandom_range(0, 1) ? "b" : "B");
          q = $urandom_range(0, 1) ? "'" : "\"";
          text.push_back(q);
          nelem = ($urandom_range(0, 39) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 10);
          repeat (nelem) begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3: begin
                do ch = 8'($urandom_range(0, 255)); while (ch == q || ch == "\\");
                text.push_back(ch);
              end
              4: begin
                text.push_back("\\");
                text.push_back(named_set[$urandom_range(0, named_set.len() - 1)]);
              end
              5: begin
                text.push_back("\\");
                text.push_back(q);
              end
              6: begin
                text.push_back("\\");
                text.push_back($urandom_range(0, 1) ? "x" : "X");
                text.push_back(hex_set[$urandom_range(0, hex_set.len() - 1)]);
                if ($urandom_range(0, 9) == 0) text.push_back(8'($urandom_range(0, 255)));
                else text.push_back(hex_set[$urandom_range(0, hex_set.len() - 1)]);
              end
              7, 8: begin
                text.push_back("\\");
                nd = $urandom_range(1, 3);
                // A leading digit above 3 makes a three-digit escape overflow.
                if ($urandom_range(0, 4) == 0) text.push_back(8'("0" + $urandom_range(0, 7)));
                else text.push_back(8'("0" + $urandom_range(0, 3)));
                repeat (nd - 1) text.push_back(8'("0" + $urandom_range(0, 7)));
              end
              default: begin
                text.push_back("\\");
                text.push_back(8'($urandom_range(0, 255)));
              end
            endcase
          end
          text.push_back(q);
        end
        if (flavor < 4) begin
          pos = $urandom_range(1, text.size() - 1);
          while (text.size() > pos) void'(text.pop_back());
        end else if (flavor < 6) begin
          text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
        end
      end
      send_text(text);
    end
    steady_flow = 1'b0;
  endtask

  initial begin : result_checker
    bled_pkg::res_t want;
    int   stall_left;
    stall_left = 0;
    res_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && res_ready) begin
        if (pending_words.size() == 0) begin
          log_mismatch($sformatf("unexpected word %p", res_data));
        end else begin
          want = pending_words.pop_front();
          if (res_data.kind !== want.kind || res_data.byte_out !== want.byte_out ||
              res_data.byte_count !== want.byte_count ||
              res_data.run_end !== want.run_end)
            log_mismatch($sformatf("expected %p, got %p", want, res_data));
        end
        stall_left = steady_flow ? 0 : $urandom_range(0, 8);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      res_ready <= (stall_left == 0);
    end
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst       <= 1'b1;
    src_valid <= 1'b0;
    src_data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_octal_end();
    test_octal_overflow();
    test_bad_prefix();
    test_bad_quote();
    test_unterminated();
    test_trailing_text();
    test_raw_extremes();
    test_random_literals();
    src_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
